### sv/rhit_pkg.sv
`timescale 1ns / 1ps
package rhit_pkg;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_HIT       = 3'd1,
		ST_FULL      = 3'd2,
		ST_COLLISION = 3'd3,
		ST_DECR      = 3'd4,
		ST_FREED     = 3'd5,
		ST_NOT_FOUND = 3'd6
	} status_t;

	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BS_READ,
		S_BS_CMP,
		S_RUN_READ,
		S_RUN_SLOT,
		S_RUN_CMP,
		S_INS_READ,
		S_INS_WRITE,
		S_INS_FINAL,
		S_DEL_READ,
		S_DEL_WRITE,
		S_DUMMY_READ,
		S_DUMMY_WAIT,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic bs_init;
		logic idx_rd_mid;
		logic bs_step;
		logic run_init;
		logic idx_rd_run;
		logic slot_rd_run;
		logic run_next;
		logic do_hit;
		logic do_decr;
		logic do_free;
		logic ins_init;
		logic ins_rd;
		logic ins_wr;
		logic ins_final;
		logic del_rd;
		logic del_wr;
		logic del_final;
		logic dummy_rd;
		logic set_full;
		logic set_coll;
		logic set_nf;
		logic out_set;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_release;
		logic bs_done;
		logic run_end;
		logic tag_match;
		logic slot_match;
		logic cnt_gt1;
		logic pos_hit;
		logic no_free;
		logic ins_done;
		logic del_done;
	} sts_t;

endpackage

### sv/rhit_if.sv
`timescale 1ns / 1ps
interface rhit_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic signed [31:0] hash_key;
	logic [63:0] content_tag;
	logic [7:0]  slot_index;
	modport source (output valid, req_type, hash_key, content_tag, slot_index, input ready);
	modport sink (input valid, req_type, hash_key, content_tag, slot_index, output ready);
endinterface

interface rhit_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  result_slot;
	logic [2:0]  status;
	logic [15:0] ref_count;
	modport source (output valid, result_slot, status, ref_count, input ready);
	modport sink (input valid, result_slot, status, ref_count, output ready);
endinterface

### sv/rhit_ctrl.sv
`timescale 1ns / 1ps
module rhit_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  rhit_pkg::sts_t  sts,
	output rhit_pkg::cmd_t  cmd
);
	rhit_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rhit_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rhit_pkg::S_IDLE: if (in_valid) state_d = rhit_pkg::S_BS_READ;
			rhit_pkg::S_BS_READ: begin
				if (sts.bs_done) state_d = rhit_pkg::S_RUN_READ;
				else state_d = rhit_pkg::S_BS_CMP;
			end
			rhit_pkg::S_BS_CMP: state_d = rhit_pkg::S_BS_READ;
			rhit_pkg::S_RUN_READ: begin
				// first look at lower-bound position decides absent hash
				if (sts.run_end) begin
					if (sts.is_release) state_d = rhit_pkg::S_OUT;
					else if (!sts.pos_hit && sts.no_free) state_d = rhit_pkg::S_DUMMY_READ;
					else if (!sts.pos_hit) state_d = rhit_pkg::S_INS_READ;
					else state_d = rhit_pkg::S_DUMMY_READ;
				end else state_d = rhit_pkg::S_RUN_SLOT;
			end
			rhit_pkg::S_RUN_SLOT: state_d = rhit_pkg::S_RUN_CMP;
			rhit_pkg::S_RUN_CMP: begin
				if (sts.is_release) begin
					if (sts.slot_match) begin
						if (sts.cnt_gt1) state_d = rhit_pkg::S_OUT;
						else state_d = rhit_pkg::S_DEL_READ;
					end else state_d = rhit_pkg::S_RUN_READ;
				end else begin
					if (sts.tag_match) state_d = rhit_pkg::S_OUT;
					else state_d = rhit_pkg::S_RUN_READ;
				end
			end
			rhit_pkg::S_INS_READ: begin
				if (sts.ins_done) state_d = rhit_pkg::S_INS_FINAL;
				else state_d = rhit_pkg::S_INS_WRITE;
			end
			rhit_pkg::S_INS_WRITE: state_d = rhit_pkg::S_INS_READ;
			rhit_pkg::S_INS_FINAL: state_d = rhit_pkg::S_OUT;
			rhit_pkg::S_DEL_READ: begin
				if (sts.del_done) state_d = rhit_pkg::S_OUT;
				else state_d = rhit_pkg::S_DEL_WRITE;
			end
			rhit_pkg::S_DEL_WRITE: state_d = rhit_pkg::S_DEL_READ;
			rhit_pkg::S_DUMMY_READ: state_d = rhit_pkg::S_DUMMY_WAIT;
			rhit_pkg::S_DUMMY_WAIT: state_d = rhit_pkg::S_OUT;
			rhit_pkg::S_OUT: if (out_ready) state_d = rhit_pkg::S_IDLE;
			default: state_d = rhit_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			rhit_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.bs_init = in_valid;
			end
			rhit_pkg::S_BS_READ: begin
				cmd.idx_rd_mid = !sts.bs_done;
				cmd.run_init = sts.bs_done;
			end
			rhit_pkg::S_BS_CMP: cmd.bs_step = 1'b1;
			rhit_pkg::S_RUN_READ: begin
				if (sts.run_end) begin
					if (sts.is_release) cmd.set_nf = 1'b1;
					else if (!sts.pos_hit && sts.no_free) begin
						cmd.dummy_rd = 1'b1;
						cmd.set_full = 1'b1;
					end else if (!sts.pos_hit) cmd.ins_init = 1'b1;
					else begin
						cmd.dummy_rd = 1'b1;
						cmd.set_coll = 1'b1;
					end
				end else cmd.idx_rd_run = 1'b1;
			end
			rhit_pkg::S_RUN_SLOT: cmd.slot_rd_run = 1'b1;
			rhit_pkg::S_RUN_CMP: begin
				if (sts.is_release) begin
					if (sts.slot_match) begin
						if (sts.cnt_gt1) cmd.do_decr = 1'b1;
						else cmd.do_free = 1'b1;
					end else cmd.run_next = 1'b1;
				end else begin
					if (sts.tag_match) cmd.do_hit = 1'b1;
					else cmd.run_next = 1'b1;
				end
			end
			rhit_pkg::S_INS_READ: cmd.ins_rd = !sts.ins_done;
			rhit_pkg::S_INS_WRITE: cmd.ins_wr = 1'b1;
			rhit_pkg::S_INS_FINAL: cmd.ins_final = 1'b1;
			rhit_pkg::S_DEL_READ: begin
				cmd.del_rd = !sts.del_done;
				cmd.del_final = sts.del_done;
			end
			rhit_pkg::S_DEL_WRITE: cmd.del_wr = 1'b1;
			rhit_pkg::S_DUMMY_WAIT: cmd.out_set = 1'b1;
			rhit_pkg::S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

### sv/rhit_dp.sv
`timescale 1ns / 1ps
module rhit_dp #(
	parameter int SLOTS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rhit_pkg::cmd_t  cmd,
	output rhit_pkg::sts_t  sts,
	input  logic            req_type,
	input  logic [31:0]     hash_key,
	input  logic [63:0]     content_tag,
	input  logic [7:0]      slot_index,
	output logic [7:0]      result_slot,
	output logic [2:0]      status,
	output logic [15:0]     ref_count
);
	localparam int SW = $clog2(SLOTS);
	localparam int CW = SW + 1;
	localparam logic [SW-1:0] DUMMY = SW'(SLOTS - 1);

	// index memory: key with sign inverted, slot id
	logic [31:0]   idx_hash_mem [SLOTS];
	logic [SW-1:0] idx_slot_mem [SLOTS];
	logic [SW-1:0] free_mem [SLOTS];
	logic [63:0]   tag_mem [SLOTS];
	logic [15:0]   cnt_mem [SLOTS];
	logic [SLOTS-1:0] cnt_vld_q;

	logic [31:0]   rd_hash_q;
	logic [SW-1:0] rd_slot_q;
	logic [63:0]   rd_tag_q;
	logic [15:0]   rd_cnt_raw_q;
	logic [SW-1:0] rd_cnt_addr_q;
	logic [SW-1:0] rd_free_q;
	logic [15:0]   rd_cnt;

	logic          req_q;
	logic [31:0]   key_q;
	logic [63:0]   tag_q;
	logic [7:0]    rel_q;
	logic [CW-1:0] lo_q, hi_q, run_q, sh_q;
	logic [CW-1:0] entry_q, free_q;
	logic          pos_chk_q;
	logic          pos_hit_q;
	logic [7:0]    res_slot_q;
	logic [2:0]    res_status_q;
	logic [15:0]   res_cnt_q;
	logic [CW-1:0] mid;
	logic          hash_eq;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_cnt = cnt_vld_q[rd_cnt_addr_q] ? rd_cnt_raw_q : 16'd0;
	assign hash_eq = (rd_hash_q == key_q);

	// free stack entries below the low-water mark still hold SLOTS-1-k
	logic [CW-1:0]    free_low_q;
	logic [SW-1:0]    free_top_addr_q;
	logic [SW-1:0]    free_pop;
	assign free_pop = (free_q == free_low_q) ? DUMMY - free_top_addr_q : rd_free_q;

	assign sts.is_release = req_q;
	assign sts.bs_done    = !(lo_q < hi_q);
	assign sts.run_end    = (run_q >= entry_q) || (pos_chk_q ? 1'b0 : !hash_eq);
	assign sts.tag_match  = hash_eq && (rd_tag_q == tag_q);
	assign sts.slot_match = hash_eq && (32'(rd_slot_q) == 32'(rel_q));
	assign sts.cnt_gt1    = rd_cnt > 16'd1;
	assign sts.pos_hit    = pos_hit_q;
	assign sts.no_free    = (free_q == '0);
	assign sts.ins_done   = (sh_q <= lo_q);
	assign sts.del_done   = (sh_q + 1'b1 >= entry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			free_q <= CW'(SLOTS);
			free_low_q <= CW'(SLOTS);
			cnt_vld_q <= '0;
		end else begin
			if (cmd.ins_final) begin
				entry_q <= entry_q + 1'b1;
				free_q <= free_q - 1'b1;
				cnt_vld_q[free_pop] <= 1'b1;
				if (free_q == free_low_q) free_low_q <= free_q - 1'b1;
			end
			if (cmd.del_final) entry_q <= entry_q - 1'b1;
			if (cmd.do_free) free_q <= free_q + 1'b1;
		end
	end

	// memories and sequencing registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= hash_key ^ 32'h8000_0000;
			tag_q <= content_tag;
			rel_q <= slot_index;
		end
		if (cmd.bs_init) begin
			lo_q <= '0;
			hi_q <= entry_q;
		end
		if (cmd.idx_rd_mid) rd_hash_q <= idx_hash_mem[mid[SW-1:0]];
		if (cmd.bs_step) begin
			if (rd_hash_q < key_q) lo_q <= mid + 1'b1;
			else hi_q <= mid;
		end
		if (cmd.run_init) begin
			run_q <= lo_q;
			pos_chk_q <= 1'b1;
			pos_hit_q <= 1'b0;
		end
		if (cmd.idx_rd_run) begin
			rd_hash_q <= idx_hash_mem[run_q[SW-1:0]];
			rd_slot_q <= idx_slot_mem[run_q[SW-1:0]];
			pos_chk_q <= 1'b0;
		end
		if (cmd.slot_rd_run) begin
			if (hash_eq) pos_hit_q <= 1'b1;
			rd_tag_q <= tag_mem[rd_slot_q];
			rd_cnt_raw_q <= cnt_mem[rd_slot_q];
			rd_cnt_addr_q <= rd_slot_q;
		end
		if (cmd.run_next) begin
			run_q <= run_q + 1'b1;
			pos_chk_q <= 1'b0;
		end
		if (cmd.do_hit) begin
			res_slot_q <= 8'(rd_slot_q);
			res_status_q <= rhit_pkg::ST_HIT;
			res_cnt_q <= (rd_cnt == 16'hFFFF) ? rd_cnt : rd_cnt + 1'b1;
			if (rd_cnt != 16'hFFFF) cnt_mem[rd_slot_q] <= rd_cnt + 1'b1;
		end
		if (cmd.do_decr) begin
			res_slot_q <= 8'(rd_slot_q);
			res_status_q <= rhit_pkg::ST_DECR;
			res_cnt_q <= rd_cnt - 1'b1;
			cnt_mem[rd_slot_q] <= rd_cnt - 1'b1;
		end
		if (cmd.do_free) begin
			res_slot_q <= 8'(rd_slot_q);
			res_status_q <= rhit_pkg::ST_FREED;
			res_cnt_q <= '0;
			cnt_mem[rd_slot_q] <= '0;
			free_mem[free_q[SW-1:0]] <= rd_slot_q;
			sh_q <= run_q;
		end
		if (cmd.del_rd) begin
			rd_hash_q <= idx_hash_mem[SW'(sh_q + 1'b1)];
			rd_slot_q <= idx_slot_mem[SW'(sh_q + 1'b1)];
		end
		if (cmd.del_wr) begin
			idx_hash_mem[sh_q[SW-1:0]] <= rd_hash_q;
			idx_slot_mem[sh_q[SW-1:0]] <= rd_slot_q;
			sh_q <= sh_q + 1'b1;
		end
		if (cmd.set_nf) begin
			res_slot_q <= rel_q;
			res_status_q <= rhit_pkg::ST_NOT_FOUND;
			res_cnt_q <= '0;
		end
		if (cmd.ins_init) begin
			sh_q <= entry_q;
			rd_free_q <= free_mem[SW'(free_q - 1'b1)];
			free_top_addr_q <= SW'(free_q - 1'b1);
		end
		if (cmd.ins_rd) begin
			rd_hash_q <= idx_hash_mem[SW'(sh_q - 1'b1)];
			rd_slot_q <= idx_slot_mem[SW'(sh_q - 1'b1)];
		end
		if (cmd.ins_wr) begin
			idx_hash_mem[sh_q[SW-1:0]] <= rd_hash_q;
			idx_slot_mem[sh_q[SW-1:0]] <= rd_slot_q;
			sh_q <= sh_q - 1'b1;
		end
		if (cmd.ins_final) begin
			idx_hash_mem[lo_q[SW-1:0]] <= key_q;
			idx_slot_mem[lo_q[SW-1:0]] <= free_pop;
			tag_mem[free_pop] <= tag_q;
			cnt_mem[free_pop] <= 16'd1;
			res_slot_q <= 8'(free_pop);
			res_status_q <= rhit_pkg::ST_INSERTED;
			res_cnt_q <= 16'd1;
		end
		if (cmd.dummy_rd) begin
			rd_cnt_raw_q <= cnt_mem[DUMMY];
			rd_cnt_addr_q <= DUMMY;
			res_slot_q <= 8'(DUMMY);
		end
		if (cmd.set_full) res_status_q <= rhit_pkg::ST_FULL;
		if (cmd.set_coll) res_status_q <= rhit_pkg::ST_COLLISION;
		if (cmd.out_set) res_cnt_q <= rd_cnt;
	end

	assign result_slot = res_slot_q;
	assign status = res_status_q;
	assign ref_count = res_cnt_q;
endmodule

### sv/refcounted_hash_intern_table.sv
`timescale 1ns / 1ps
// Reference-counted intern table. One request at a time: an acquire or a
// release runs a lower-bound search, then scans the equal-hash run, and
// then moves index entries one by one when inserting or closing a gap.
// The result beat stays until taken.
module refcounted_hash_intern_table #(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	rhit_req_if.sink    req,
	rhit_rsp_if.source  rsp
);
	rhit_pkg::cmd_t cmd;
	rhit_pkg::sts_t sts;

	rhit_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	rhit_dp #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req.req_type), .hash_key(req.hash_key),
		.content_tag(req.content_tag), .slot_index(req.slot_index),
		.result_slot(rsp.result_slot), .status(rsp.status),
		.ref_count(rsp.ref_count)
	);
endmodule

### sv/rhit_checker.sv
`timescale 1ns / 1ps
module rhit_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [15:0] ref_count
);
	// one request at a time
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rhit_pkg::ST_INSERTED |-> ref_count == 16'd1)
		else $error("insert count");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rhit_pkg::ST_FREED || status == rhit_pkg::ST_NOT_FOUND)
		|-> ref_count == 16'd0)
		else $error("free count");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= rhit_pkg::ST_NOT_FOUND) else $error("bad status");
endmodule

bind refcounted_hash_intern_table rhit_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.status(rsp.status), .ref_count(rsp.ref_count)
);
